// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker of the console engine.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is asserted
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/tcce_pkg.sv =====
// Package of the text console cursor engine: geometry defaults, character codes,
// action and register codes, state type and stream word widths. No dependencies.
`default_nettype none

package tcce_pkg;

    // Screen geometry defaults
    localparam int DEF_ROWS = 25;
    localparam int DEF_COLS = 80;

    // Attribute reset values
    localparam logic [7:0] TEXT_ATTR_RESET  = 8'h0F;
    localparam logic [7:0] BLANK_ATTR_RESET = 8'h07;

    // Tab stop spacing, a power of two
    localparam int TAB_STOP = 4;

    // Control characters
    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 1'd1;

    // Stream word widths
    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_SCROLL,
        ST_FILL,
        ST_CLEAR,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/text_console_cursor_engine.sv =====
// Text console cursor engine: screen cell memory, cursor and control-code handling.
// Depends on tcce_pkg.
//
// Usage: input words arrive on s_tvalid/s_tready with the action in s_tuser and the
// character and read coordinates in s_tdata. Each input word yields one result word on
// m_tvalid/m_tready with the read cell, the cursor position and a scroll flag.
// Attribute registers are written through cfg_valid/cfg_ready (always ready); the user
// must write them only while the engine is idle, as the engine itself does not enforce it.
// Throughput: one word at a time; a new word is accepted only once the last result is
// presented. Each word passes IDLE, EXEC and EMIT, a read also RDWAIT. A clear sweeps
// every cell in CLEAR, and a character that scrolls copies every cell up a row in SCROLL
// and blanks the last row in FILL, both through the single write port of the cell
// memory that moves one cell per cycle.
// Reset: a sweep zeroes every cell of the cell memory; s_tready stays low
// during it. Cursor homes, attributes return to 0x0F and 0x07.
// Stall: a finished result waits in the output register while the next word is
// accepted and processed; the engine holds before presenting a further result.
`default_nettype none

module text_console_cursor_engine #(
    parameter int ROWS = tcce_pkg::DEF_ROWS,
    parameter int COLS = tcce_pkg::DEF_COLS
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // s_tdata: char_code[7:0], read_row[12:8], read_col[19:13], zero pad[23:20]
    input  wire  [tcce_pkg::S_DATA_W-1:0]   s_tdata,
    // s_tuser: action[1:0]
    input  wire  [tcce_pkg::S_USER_W-1:0]   s_tuser,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // m_tdata: cell_value[15:0], cursor_col[22:16], cursor_row[27:23], scrolled[28],
    // zero pad[31:29]
    output logic [tcce_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  wire                             m_tready,
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [7:0]                      cfg_data
);
    import tcce_pkg::*;

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLS);
    localparam int CW1   = CW + 1;
    localparam int RW    = $clog2(ROWS);

    // Cell memory, attribute high byte, character low byte
    logic [15:0] mem [0:CELLS-1];
    logic [15:0] mem_rdata_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    state_t state_reg, state_next;

    logic [AW-1:0] idx_reg, idx_next;
    logic          cp_valid_reg, cp_valid_next;
    logic [AW-1:0] cp_waddr_reg, cp_waddr_next;
    logic          rd_done_reg, rd_done_next;
    logic          clr_item_reg, clr_item_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [7:0]    text_attr_reg, blank_attr_reg;
    logic          m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // Item and result payload
    logic [1:0]  act_reg, act_next;
    logic [7:0]  code_reg, code_next;
    logic [4:0]  rrow_reg, rrow_next;
    logic [6:0]  rcol_reg, rcol_next;
    logic        rd_ok_reg, rd_ok_next;
    logic [15:0] res_cell_reg, res_cell_next;
    logic        res_scr_reg, res_scr_next;

    // Cursor arithmetic
    logic [AW-1:0]  row_base;
    logic [CW1-1:0] col_ext, col_inc, col_tab;
    logic [AW-1:0]  rd_addr;
    logic           rd_ok;
    logic [5:0]     row_w;

    assign row_base = AW'(row_reg) * AW'(COLS);
    assign col_ext  = CW1'(col_reg);
    assign col_inc  = col_ext + CW1'(1);
    assign col_tab  = (col_ext | CW1'(TAB_STOP - 1)) + CW1'(1);
    assign rd_ok    = (7'(rrow_reg) < 7'(ROWS)) && (8'(rcol_reg) < 8'(COLS));
    assign rd_addr  = AW'(rrow_reg) * AW'(COLS) + AW'(rcol_reg);
    assign row_w    = 6'(row_reg);

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg        <= '0;
            cp_valid_reg   <= 1'b0;
            rd_done_reg    <= 1'b0;
            clr_item_reg   <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            text_attr_reg  <= TEXT_ATTR_RESET;
            blank_attr_reg <= BLANK_ATTR_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            cp_valid_reg <= cp_valid_next;
            rd_done_reg  <= rd_done_next;
            clr_item_reg <= clr_item_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_TEXT_ATTR:  text_attr_reg  <= cfg_data;
                    REG_BLANK_ATTR: blank_attr_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        cp_waddr_reg <= cp_waddr_next;
        m_data_reg   <= m_data_next;
        act_reg      <= act_next;
        code_reg     <= code_next;
        rrow_reg     <= rrow_next;
        rcol_reg     <= rcol_next;
        rd_ok_reg    <= rd_ok_next;
        res_cell_reg <= res_cell_next;
        res_scr_reg  <= res_scr_next;
    end

    // Next state, memory access and result
    always_comb begin
        logic wrap;
        wrap          = 1'b0;
        state_next    = state_reg;
        idx_next      = idx_reg;
        cp_valid_next = cp_valid_reg;
        cp_waddr_next = cp_waddr_reg;
        rd_done_next  = rd_done_reg;
        clr_item_next = clr_item_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        act_next      = act_reg;
        code_next     = code_reg;
        rrow_next     = rrow_reg;
        rcol_next     = rcol_reg;
        rd_ok_next    = rd_ok_reg;
        res_cell_next = res_cell_reg;
        res_scr_next  = res_scr_reg;
        m_data_next   = m_data_reg;
        // drop the result once taken
        m_valid_next  = m_valid_reg && !m_tready;
        s_tready      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = '0;
        mem_raddr     = '0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    act_next      = s_tuser[1:0];
                    code_next     = s_tdata[7:0];
                    rrow_next     = s_tdata[12:8];
                    rcol_next     = s_tdata[19:13];
                    res_cell_next = '0;
                    res_scr_next  = 1'b0;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC: begin
                state_next = ST_EMIT;
                case (act_reg)
                    ACT_PUT: begin
                        case (code_reg)
                            CH_BS: begin
                                if (col_reg != '0) begin
                                    col_next  = col_reg - CW'(1);
                                    mem_we    = 1'b1;
                                    mem_waddr = row_base + AW'(col_reg) - AW'(1);
                                    mem_wdata = '0;
                                end
                            end
                            CH_TAB: begin
                                if (col_tab >= CW1'(COLS)) begin
                                    wrap = 1'b1;
                                end else begin
                                    col_next = col_tab[CW-1:0];
                                end
                            end
                            CH_LF: begin
                                wrap = 1'b1;
                            end
                            CH_CR: begin
                                col_next = '0;
                            end
                            default: begin
                                mem_we    = 1'b1;
                                mem_waddr = row_base + AW'(col_reg);
                                mem_wdata = {text_attr_reg, code_reg};
                                if (col_inc >= CW1'(COLS)) begin
                                    wrap = 1'b1;
                                end else begin
                                    col_next = col_inc[CW-1:0];
                                end
                            end
                        endcase
                        // new line, scroll when on the last row
                        if (wrap) begin
                            col_next = '0;
                            if (row_reg == RW'(ROWS - 1)) begin
                                res_scr_next  = 1'b1;
                                idx_next      = AW'(COLS);
                                cp_valid_next = 1'b0;
                                rd_done_next  = 1'b0;
                                state_next    = ST_SCROLL;
                            end else begin
                                row_next = row_reg + RW'(1);
                            end
                        end
                    end
                    ACT_CLEAR: begin
                        col_next      = '0;
                        row_next      = '0;
                        idx_next      = '0;
                        clr_item_next = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    ACT_READ: begin
                        rd_ok_next = rd_ok;
                        mem_raddr  = rd_ok ? rd_addr : '0;
                        state_next = ST_RDWAIT;
                    end
                    default: ;
                endcase
            end

            ST_RDWAIT: begin
                res_cell_next = rd_ok_reg ? mem_rdata_reg : '0;
                state_next    = ST_EMIT;
            end

            // Copy each cell up one row: read ahead, write in the following cycle
            ST_SCROLL: begin
                mem_we    = cp_valid_reg;
                mem_waddr = cp_waddr_reg;
                mem_wdata = mem_rdata_reg;
                if (!rd_done_reg) begin
                    mem_raddr     = idx_reg;
                    cp_valid_next = 1'b1;
                    cp_waddr_next = idx_reg - AW'(COLS);
                    if (idx_reg == AW'(CELLS - 1)) begin
                        rd_done_next = 1'b1;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                    end
                end else begin
                    cp_valid_next = 1'b0;
                    if (!cp_valid_reg) begin
                        idx_next   = AW'(CELLS - COLS);
                        state_next = ST_FILL;
                    end
                end
            end

            // Blank the last row
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = {blank_attr_reg, 8'h00};
                if (idx_reg == AW'(CELLS - 1)) begin
                    state_next = ST_EMIT;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            // Zero every cell, after reset or for a clear word
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = '0;
                if (idx_reg == AW'(CELLS - 1)) begin
                    idx_next      = '0;
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? ST_EMIT : ST_IDLE;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            // Hold until the output register is free
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, res_scr_reg, row_w[4:0], 7'(col_reg),
                                    res_cell_reg};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tcce_checker.sv =====
// Port-level checker of the text console cursor engine, bound to the top level.
// Depends on tcce_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcce_checker #(
    parameter int ROWS = tcce_pkg::DEF_ROWS,
    parameter int COLS = tcce_pkg::DEF_COLS
) (
    input wire                            aclk,
    input wire                            aresetn,
    input wire [tcce_pkg::S_DATA_W-1:0]   s_tdata,
    input wire [tcce_pkg::S_USER_W-1:0]   s_tuser,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire [tcce_pkg::M_DATA_W-1:0]   m_tdata,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire                            cfg_valid,
    input wire                            cfg_ready,
    input wire [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire [7:0]                      cfg_data
);
    import tcce_pkg::*;

    localparam int LAST_ROW = (ROWS - 1) % 32;

    logic [7:0] out_col;
    logic       unused_ok;

    assign out_col   = {1'b0, m_tdata[22:16]};
    assign unused_ok = ^{s_tdata, s_tuser, s_tvalid, cfg_valid, cfg_ready, cfg_index, cfg_data};

    // Cursor column on the result stays on the screen
    `ASSERT_IMP(a_col_range, aclk, aresetn, m_tvalid, out_col < 8'(COLS) || unused_ok !== unused_ok)

    // A scroll leaves the cursor at the start of the last row
    `ASSERT_IMP(a_scroll_home, aclk, aresetn, m_tvalid && m_tdata[28], m_tdata[22:16] == 7'd0 && m_tdata[27:23] == 5'(LAST_ROW))

    // One word in flight: input stalls right after an accept
    `ASSERT_NXT(a_one_word, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A stalled result stays presented
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

endmodule

bind text_console_cursor_engine tcce_checker #(
    .ROWS(ROWS),
    .COLS(COLS)
) u_tcce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
);

`default_nettype wire
